### rtl/core/fnv_pkg.sv
// Package for the FNV-1 64-bit short-key hash block.
// Holds widths, constants, the queue entry type and item kind codes.
// No dependencies; every other file of the block uses it.
package fnv_pkg;

  localparam int HASH_W          = 64;
  localparam int BYTE_W          = 8;
  localparam int CNT_W           = 4;
  localparam int SHORT_KEY_BYTES = 8;
  localparam int COUNT_SAT       = SHORT_KEY_BYTES + 1;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [1:0] fnv_kind_t;

  localparam fnv_kind_t KIND_BYTE  = 2'd0;
  localparam fnv_kind_t KIND_LAST  = 2'd1;
  localparam fnv_kind_t KIND_EMPTY = 2'd2;

  typedef struct packed {
    fnv_kind_t          kind;
    logic [BYTE_W-1:0]  data;
  } fnv_q_entry_t;

endpackage

### rtl/core/fnv_in_if.sv
// Input channel interface: one key byte per beat with its markers.
// Depends on fnv_pkg for the byte width.
interface fnv_in_if;
  logic                          valid;
  logic                          ready;
  logic [fnv_pkg::BYTE_W-1:0]    data_byte;
  logic                          last_byte;
  logic                          empty_message;

  modport source (output valid, output data_byte, output last_byte,
                  output empty_message, input ready);
  modport sink   (input valid, input data_byte, input last_byte,
                  input empty_message, output ready);
endinterface

### rtl/core/fnv_out_if.sv
// Result channel interface: a 64-bit digest and the packed-key flag.
// Depends on fnv_pkg for the digest width.
interface fnv_out_if;
  logic                          valid;
  logic                          ready;
  logic [fnv_pkg::HASH_W-1:0]    digest;
  logic                          was_packed;

  modport source (output valid, output digest, output was_packed, input ready);
  modport sink   (input valid, input digest, input was_packed, output ready);
endinterface

### rtl/core/fnv_front.sv
// Front end: accepts input beats, classifies them and queues them.
// Depends on fnv_pkg and fnv_in_if.
module fnv_front (
  input  logic                  clk,
  input  logic                  rst_n,
  fnv_in_if.sink                in_bus,
  output logic                  q_valid,
  output fnv_pkg::fnv_q_entry_t q_entry,
  input  logic                  q_pop
);
  import fnv_pkg::*;

  fnv_q_entry_t      mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  fnv_q_entry_t      new_entry;

  // An empty-key beat overrides the last marker.
  always_comb begin
    new_entry.data = in_bus.data_byte;
    if (in_bus.empty_message) begin
      new_entry.kind = KIND_EMPTY;
    end else if (in_bus.last_byte) begin
      new_entry.kind = KIND_LAST;
    end else begin
      new_entry.kind = KIND_BYTE;
    end
  end

  assign in_bus.ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push         = in_bus.valid && in_bus.ready;
  assign q_valid      = (count_r != '0);
  assign q_entry      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  a_pop_only_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !push) |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count did not drop on a lone pop");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from an empty queue");
`endif

endmodule

### rtl/core/fnv_back.sv
// Back end: runs the FNV-1 hash, packs short keys and holds the result register.
// Depends on fnv_pkg and fnv_out_if; also holds the salt register.
module fnv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fnv_pkg::HASH_W-1:0]  cfg_wdata,
  input  logic                        q_valid,
  input  fnv_pkg::fnv_q_entry_t       q_entry,
  output logic                        q_pop,
  fnv_out_if.source                   out_bus
);
  import fnv_pkg::*;

  logic [HASH_W-1:0] salt_r;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [HASH_W-1:0] packed_r, packed_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0] digest_r, digest_nxt;
  logic              was_packed_r, was_packed_nxt;
  logic [HASH_W-1:0] base;
  logic [HASH_W-1:0] hash_upd;
  logic [HASH_W-1:0] packed_upd;
  logic [CNT_W-1:0]  cnt_upd;
  logic              res_fire;

  // Multiply by the 64-bit FNV prime 0x100000001b3, modulo 2^64.
  function automatic logic [HASH_W-1:0] prime_mul(input logic [HASH_W-1:0] h);
    prime_mul = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
  endfunction

  assign q_pop = q_valid && (!out_valid_r || out_bus.ready);

  always_comb begin
    base     = (cnt_r == '0) ? salt_r : hash_r;
    hash_upd = prime_mul(base) ^ {{(HASH_W-BYTE_W){1'b0}}, q_entry.data};

    packed_upd = packed_r;
    for (int i = 0; i < SHORT_KEY_BYTES; i++) begin
      if (cnt_r == CNT_W'(i)) begin
        packed_upd[i*BYTE_W +: BYTE_W] = q_entry.data;
      end
    end
    cnt_upd = (cnt_r < CNT_W'(COUNT_SAT)) ? cnt_r + 1'b1 : cnt_r;
  end

  always_comb begin
    hash_nxt       = hash_r;
    packed_nxt     = packed_r;
    cnt_nxt        = cnt_r;
    digest_nxt     = digest_r;
    was_packed_nxt = was_packed_r;
    res_fire       = 1'b0;
    if (q_pop) begin
      unique case (q_entry.kind)
        KIND_BYTE: begin
          hash_nxt   = hash_upd;
          packed_nxt = packed_upd;
          cnt_nxt    = cnt_upd;
        end
        KIND_LAST: begin
          res_fire   = 1'b1;
          hash_nxt   = hash_upd;
          packed_nxt = '0;
          cnt_nxt    = '0;
          if (cnt_upd <= CNT_W'(SHORT_KEY_BYTES)) begin
            digest_nxt     = packed_upd;
            was_packed_nxt = 1'b1;
          end else begin
            digest_nxt     = hash_upd;
            was_packed_nxt = 1'b0;
          end
        end
        default: begin
          // Empty key: emit zero and start over.
          res_fire       = 1'b1;
          packed_nxt     = '0;
          cnt_nxt        = '0;
          digest_nxt     = '0;
          was_packed_nxt = 1'b0;
        end
      endcase
    end
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_r      <= FNV_BASIS;
      packed_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        salt_r <= cfg_wdata;
      end
      packed_r    <= packed_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The running hash is only read once the count is nonzero, so it needs no reset.
  always_ff @(posedge clk) begin
    hash_r       <= hash_nxt;
    digest_r     <= digest_nxt;
    was_packed_r <= was_packed_nxt;
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.digest     = digest_r;
  assign out_bus.was_packed = was_packed_r;

`ifndef SYNTHESIS
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(COUNT_SAT))
    else $error("byte count above saturation");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.kind == KIND_EMPTY) |=>
      (out_valid_r && digest_r == '0 && !was_packed_r && cnt_r == '0))
    else $error("empty key did not give a zero result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.kind == KIND_LAST) |=> (out_valid_r && cnt_r == '0 && packed_r == '0))
    else $error("last byte did not clear the key state");

  a_packed_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.kind == KIND_LAST && cnt_r == '0) |=>
      (was_packed_r && digest_r[HASH_W-1:BYTE_W] == '0))
    else $error("one-byte key has nonzero upper digest bytes");
`endif

endmodule

### rtl/core/fnv1_64_hash_short_key_pack.sv
// Top level of the FNV-1 64-bit short-key hash block.
// Depends on fnv_pkg, fnv_in_if, fnv_out_if, fnv_front and fnv_back.

// The block takes one key byte per beat and, while results are taken, sustains
// one beat per clock; a final or empty-key beat's result passes through the
// queue and the result register to the output. That rate is set by the back
// end, which multiplies the 64-bit running hash by the FNV prime as a single
// shift-and-add step. A two-entry queue separates input acceptance from the
// hash engine, so a stalled result only backs up the input once the queue is
// full. Keys of one to eight bytes return their bytes packed little-endian
// with was_packed set; longer keys return the FNV-1 hash seeded from the salt;
// an empty key returns zero. Write the salt only while no key is in flight.
module fnv1_64_hash_short_key_pack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fnv_pkg::HASH_W-1:0]  cfg_wdata,
  fnv_in_if.sink                      in_bus,
  fnv_out_if.source                   out_bus
);
  import fnv_pkg::*;

  logic         q_valid;
  logic         q_pop;
  fnv_q_entry_t q_entry;

  fnv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  fnv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_bus   (out_bus)
  );

endmodule
